FILE: hdl/cfc_pkg.sv
// Types, command codes and query tables shared by the flash command block.
package cfc_pkg;

  // Command mode of the flash device
  typedef enum logic [3:0] {
    M_READ        = 4'd0,
    M_CFI         = 4'd1,
    M_UNLOCK      = 4'd2,
    M_COMMAND     = 4'd3,
    M_ID          = 4'd4,
    M_ERASE_SETUP = 4'd5,
    M_ERASE_UNLK  = 4'd6,
    M_ERASE_CMD   = 4'd7,
    M_PROGRAM     = 4'd8
  } mode_t;

  // Sequencer state of the top level
  typedef enum logic [2:0] {
    S_CLEAR = 3'd0,
    S_IDLE  = 3'd1,
    S_RD    = 3'd2,
    S_PROG  = 3'd3,
    S_ERASE = 3'd4
  } seq_t;

  // Access kinds
  localparam logic [2:0] REQ_RD8  = 3'd0;
  localparam logic [2:0] REQ_RD16 = 3'd1;
  localparam logic [2:0] REQ_RD32 = 3'd2;
  localparam logic [2:0] REQ_WR8  = 3'd3;
  localparam logic [2:0] REQ_WR16 = 3'd4;

  // Command data
  localparam logic [15:0] CMD_CFI_QUERY = 16'h0098;
  localparam logic [15:0] CMD_UNLOCK1   = 16'h00AA;
  localparam logic [15:0] CMD_UNLOCK2   = 16'h0055;
  localparam logic [15:0] CMD_ID        = 16'h0090;
  localparam logic [15:0] CMD_ERASE     = 16'h0080;
  localparam logic [15:0] CMD_PROGRAM   = 16'h00A0;
  localparam logic [15:0] CMD_SEC_ERASE = 16'h0030;
  localparam logic [15:0] CMD_CHIP_ERS  = 16'h0010;
  localparam logic [15:0] CMD_RESET     = 16'h00F0;

  // Command word addresses (halfword units)
  localparam logic [11:0] WORD_CFI_QUERY = 12'h055;
  localparam logic [11:0] WORD_UNLOCK1   = 12'h555;
  localparam logic [11:0] WORD_UNLOCK2   = 12'h2AA;

  localparam int unsigned CFI_FIRST_WORD = 16;
  localparam int unsigned CFI_LEN        = 65;
  localparam logic [6:0]  CFI_SIZE_IDX   = 7'h17;
  localparam logic [6:0]  CFI_REGION_IDX = 7'h1D;
  localparam int unsigned ID_LEN         = 16;

  localparam logic [7:0] CFI_BASE [CFI_LEN] = '{
    8'h51, 8'h52, 8'h59, 8'h02, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h27, 8'h36, 8'h00, 8'h00, 8'h06, 8'h06, 8'h09, 8'h13, 8'h03, 8'h05, 8'h03,
    8'h02, 8'h1B, 8'h02, 8'h00, 8'h06, 8'h00, 8'h01, 8'hFF, 8'h03, 8'h00, 8'h02,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h50, 8'h52, 8'h49, 8'h31, 8'h33, 8'h14, 8'h02,
    8'h01, 8'h00, 8'h08, 8'h00, 8'h00, 8'h02, 8'hB5, 8'hC5, 8'h04, 8'h01
  };

  localparam logic [7:0] ID_TABLE [ID_LEN] = '{
    8'h01, 8'h7E, 8'h00, 8'h19, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h21, 8'h01
  };

  // Decoder actions handed to the sequencer
  typedef struct packed {
    mode_t      mode_nxt;
    logic       arr_rd;
    logic       prog;
    logic       erase;
    logic [7:0] tbl_data;
  } cfc_act_t;

  // Query table entry with the density-dependent entries patched in
  function automatic logic [7:0] cfi_entry(input logic [6:0] idx, input logic [1:0] size_code);
    logic [7:0] val;
    val = 8'h00;
    if (idx == CFI_SIZE_IDX) begin
      val = 8'h18 + {6'd0, size_code};
    end else if (idx == CFI_REGION_IDX) begin
      val = (size_code == 2'd0) ? 8'h7F : 8'hFF;
    end else if (idx == CFI_REGION_IDX + 7'd1) begin
      case (size_code)
        2'd2:    val = 8'h01;
        2'd3:    val = 8'h03;
        default: val = 8'h00;
      endcase
    end else if (idx == CFI_REGION_IDX + 7'd2) begin
      val = 8'h00;
    end else if (idx == CFI_REGION_IDX + 7'd3) begin
      val = 8'h02;
    end else if (idx < 7'(CFI_LEN)) begin
      val = CFI_BASE[idx];
    end
    return val;
  endfunction

endpackage

FILE: hdl/cfc_cmd_dec.sv
// Command decoder: mode transitions, actions and query/ID table reads.
module cfc_cmd_dec #(
  parameter int MEM_ADDR_BITS = 20
) (
  input  cfc_pkg::mode_t            mode,
  input  logic [2:0]                req_type,
  input  logic [MEM_ADDR_BITS-1:0]  byte_address,
  input  logic [15:0]               write_data,
  input  logic [1:0]                size_code,
  output cfc_pkg::cfc_act_t         act
);

  localparam int WB = MEM_ADDR_BITS - 1;

  logic [WB-1:0] word;
  logic [WB-1:0] cfi_off;
  logic          wr;
  logic          rd_narrow;
  logic          cfi_hit;
  logic          id_hit;
  logic [7:0]    cfi_val;
  logic [7:0]    id_val;

  assign word    = byte_address[MEM_ADDR_BITS-1:1];
  assign cfi_off = word - WB'(cfc_pkg::CFI_FIRST_WORD);
  assign wr      = (req_type == cfc_pkg::REQ_WR16);
  assign cfi_hit = (word >= WB'(cfc_pkg::CFI_FIRST_WORD)) &&
                   (word <  WB'(cfc_pkg::CFI_FIRST_WORD + cfc_pkg::CFI_LEN));
  assign id_hit  = (word < WB'(cfc_pkg::ID_LEN));
  assign cfi_val = cfi_hit ? cfc_pkg::cfi_entry(cfi_off[6:0], size_code) : 8'h00;
  assign id_val  = id_hit ? cfc_pkg::ID_TABLE[word[3:0]] : 8'h00;

  always_comb begin
    rd_narrow = (req_type inside {cfc_pkg::REQ_RD8, cfc_pkg::REQ_RD16});
    act = '{mode_nxt: mode, arr_rd: 1'b0, prog: 1'b0, erase: 1'b0, tbl_data: 8'h00};
    case (mode)
      cfc_pkg::M_READ: begin
        if (wr && word == WB'(cfc_pkg::WORD_CFI_QUERY) && write_data == cfc_pkg::CMD_CFI_QUERY)
          act.mode_nxt = cfc_pkg::M_CFI;
        else if (wr && word == WB'(cfc_pkg::WORD_UNLOCK1) && write_data == cfc_pkg::CMD_UNLOCK1)
          act.mode_nxt = cfc_pkg::M_UNLOCK;
        else if (req_type inside {cfc_pkg::REQ_RD8, cfc_pkg::REQ_RD16, cfc_pkg::REQ_RD32})
          act.arr_rd = 1'b1;
      end
      cfc_pkg::M_CFI: begin
        if (wr && write_data == cfc_pkg::CMD_RESET)
          act.mode_nxt = cfc_pkg::M_READ;
        else if (rd_narrow)
          act.tbl_data = cfi_val;
      end
      cfc_pkg::M_UNLOCK: begin
        if (wr && word == WB'(cfc_pkg::WORD_UNLOCK2) && write_data == cfc_pkg::CMD_UNLOCK2)
          act.mode_nxt = cfc_pkg::M_COMMAND;
      end
      cfc_pkg::M_COMMAND: begin
        if (wr && word == WB'(cfc_pkg::WORD_UNLOCK1)) begin
          if (write_data == cfc_pkg::CMD_ID)
            act.mode_nxt = cfc_pkg::M_ID;
          else if (write_data == cfc_pkg::CMD_ERASE)
            act.mode_nxt = cfc_pkg::M_ERASE_SETUP;
          else if (write_data == cfc_pkg::CMD_PROGRAM)
            act.mode_nxt = cfc_pkg::M_PROGRAM;
        end
      end
      cfc_pkg::M_PROGRAM: begin
        if (wr) begin
          act.prog     = 1'b1;
          act.mode_nxt = cfc_pkg::M_READ;
        end
      end
      cfc_pkg::M_ERASE_SETUP: begin
        if (wr && word == WB'(cfc_pkg::WORD_UNLOCK1) && write_data == cfc_pkg::CMD_UNLOCK1)
          act.mode_nxt = cfc_pkg::M_ERASE_UNLK;
      end
      cfc_pkg::M_ERASE_UNLK: begin
        if (wr && word == WB'(cfc_pkg::WORD_UNLOCK2) && write_data == cfc_pkg::CMD_UNLOCK2)
          act.mode_nxt = cfc_pkg::M_ERASE_CMD;
      end
      cfc_pkg::M_ERASE_CMD: begin
        // Chip erase leaves the array alone
        if (wr && word == WB'(cfc_pkg::WORD_UNLOCK1) && write_data == cfc_pkg::CMD_CHIP_ERS) begin
          act.mode_nxt = cfc_pkg::M_READ;
        end else if (wr && write_data == cfc_pkg::CMD_SEC_ERASE) begin
          act.erase    = 1'b1;
          act.mode_nxt = cfc_pkg::M_READ;
        end
      end
      cfc_pkg::M_ID: begin
        if (wr && write_data == cfc_pkg::CMD_RESET)
          act.mode_nxt = cfc_pkg::M_READ;
        else if (rd_narrow)
          act.tbl_data = id_val;
      end
      default: act.mode_nxt = cfc_pkg::M_READ;
    endcase
  end

endmodule

FILE: hdl/cfi_flash_command_fsm_top.sv
// Top level of the NOR flash command interpreter with its flash array.
//
// NOR flash model with the AMD command set and CFI query, one bus transaction at a
// time. After reset the array is swept to all ones, one 32-bit word per cycle, over
// all 2**(MEM_ADDR_BITS-2) words (262144 at the default); in_stall stays high during
// that sweep while size_code writes on the cfg port are taken as usual. Afterwards
// an array read goes through the registered read port of the array; a halfword
// program reads the word, then writes it merged through the single array port; a
// sector erase sweeps the sector, one word per cycle through the same port. The
// result transaction of a write carries zero and is offered at once; the block
// takes the next transaction when its sequencer is idle and the output register
// is empty or being drained. The flash array is big-endian: byte 0 of a word is
// its top byte and halfword 0 its upper half.
module cfi_flash_command_fsm_top #(
  parameter int MEM_ADDR_BITS = 20,
  parameter int SECTOR_BYTES  = 65536
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_req_type,
  input  logic [MEM_ADDR_BITS-1:0]  in_byte_address,
  input  logic [15:0]               in_write_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [31:0]               out_read_data
);

  localparam int WORD_BITS    = MEM_ADDR_BITS - 2;
  localparam int WORDS        = 1 << WORD_BITS;
  localparam int SECTOR_WORDS = SECTOR_BYTES / 4;
  localparam int SEC_BITS     = $clog2(SECTOR_WORDS);

  cfc_pkg::seq_t      state_r, state_nxt;
  cfc_pkg::mode_t     mode_r, mode_nxt;
  cfc_pkg::cfc_act_t  act;
  logic [1:0]         size_code_r;
  logic [WORD_BITS-1:0] ptr_r, ptr_nxt;
  logic [WORD_BITS-1:0] in_word;
  logic [1:0]         lane_r;
  logic [1:0]         kind_r;
  logic [15:0]        data_r;
  logic               accept;

  logic [31:0]          mem [WORDS];
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_addr;
  logic [31:0]          mem_wdata;
  logic [31:0]          mem_rdata_r;

  logic               out_valid_r;
  logic [31:0]        out_data_r;
  logic               out_load;
  logic [31:0]        out_data;
  logic [31:0]        rd_fmt;

  assign in_word       = in_byte_address[MEM_ADDR_BITS-1:2];
  // Take a transaction only when idle and the result slot is free or draining
  assign in_stall      = (state_r != cfc_pkg::S_IDLE) || (out_valid_r && out_stall);
  assign accept        = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  cfc_cmd_dec #(
    .MEM_ADDR_BITS (MEM_ADDR_BITS)
  ) u_dec (
    .mode         (mode_r),
    .req_type     (in_req_type),
    .byte_address (in_byte_address),
    .write_data   (in_write_data),
    .size_code    (size_code_r),
    .act          (act)
  );

  // Flash array: one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  // Pick the lane of the word read for the pending array read
  always_comb begin
    case (kind_r)
      2'd0: begin
        case (lane_r)
          2'd0:    rd_fmt = {24'd0, mem_rdata_r[31:24]};
          2'd1:    rd_fmt = {24'd0, mem_rdata_r[23:16]};
          2'd2:    rd_fmt = {24'd0, mem_rdata_r[15:8]};
          default: rd_fmt = {24'd0, mem_rdata_r[7:0]};
        endcase
      end
      2'd1:    rd_fmt = lane_r[1] ? {16'd0, mem_rdata_r[15:0]} : {16'd0, mem_rdata_r[31:16]};
      default: rd_fmt = mem_rdata_r;
    endcase
  end

  // Sequencer: the word pointer serves the clear sweep, the erase sweep and the
  // program read-modify-write; its incrementer serves only the two sweeps
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    ptr_nxt   = ptr_r;
    mem_we    = 1'b0;
    mem_addr  = ptr_r;
    mem_wdata = '1;
    out_load  = 1'b0;
    out_data  = '0;
    case (state_r)
      cfc_pkg::S_CLEAR: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + WORD_BITS'(1);
        if (ptr_r == '1) begin
          state_nxt = cfc_pkg::S_IDLE;
        end
      end
      cfc_pkg::S_IDLE: begin
        // Start the array read on the accept edge
        mem_addr = in_word;
        if (accept) begin
          mode_nxt = act.mode_nxt;
          ptr_nxt  = in_word;
          if (act.arr_rd) begin
            state_nxt = cfc_pkg::S_RD;
          end else begin
            out_load = 1'b1;
            out_data = {24'd0, act.tbl_data};
            if (act.prog) begin
              state_nxt = cfc_pkg::S_PROG;
            end else if (act.erase) begin
              ptr_nxt   = in_word & ~WORD_BITS'(SECTOR_WORDS - 1);
              state_nxt = cfc_pkg::S_ERASE;
            end
          end
        end
      end
      cfc_pkg::S_RD: begin
        out_load  = 1'b1;
        out_data  = rd_fmt;
        state_nxt = cfc_pkg::S_IDLE;
      end
      cfc_pkg::S_PROG: begin
        // Merge the halfword into the word just read
        mem_we    = 1'b1;
        mem_wdata = lane_r[1] ? {mem_rdata_r[31:16], data_r} : {data_r, mem_rdata_r[15:0]};
        state_nxt = cfc_pkg::S_IDLE;
      end
      cfc_pkg::S_ERASE: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + WORD_BITS'(1);
        if (ptr_r[SEC_BITS-1:0] == '1) begin
          state_nxt = cfc_pkg::S_IDLE;
        end
      end
      default: state_nxt = cfc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfc_pkg::S_CLEAR;
      mode_r      <= cfc_pkg::M_READ;
      ptr_r       <= '0;
      size_code_r <= 2'd3;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      ptr_r   <= ptr_nxt;
      if (cfg_we) begin
        size_code_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold transaction details for the later cycles and the result
  always_ff @(posedge clk) begin
    if (accept) begin
      lane_r <= in_byte_address[1:0];
      kind_r <= in_req_type[1:0];
      data_r <= in_write_data;
    end
    if (out_load) begin
      out_data_r <= out_data;
    end
  end

endmodule

FILE: hdl/cfc_chk.sv
// Port-level checker for the flash command block and its bind.
module cfc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_req_type,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_read_data
);

  logic acc;
  assign acc = in_valid && !in_stall;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed or dropped");

  // Never take a transaction while a stalled result is pending
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("transaction accepted over a stalled result");

  // Every write answers zero in the next cycle
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_req_type == cfc_pkg::REQ_WR8 || in_req_type == cfc_pkg::REQ_WR16)
      |=> out_valid && out_read_data == 32'd0)
    else $error("write result missing or nonzero");

  // A new result rises right after an accepted transaction or after its array read
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(acc, 1) || $past(acc, 2))
    else $error("result without a recent transaction");

endmodule

bind cfi_flash_command_fsm_top cfc_chk u_cfc_chk (.*);

FILE: test/cfi_flash_command_fsm_top_test.sv
// Testbench for the NOR flash command interpreter: random bus traffic checked against a predictor.
`timescale 1ns / 1ps

module cfi_flash_command_fsm_top_test;

  localparam int ADDR_BITS      = 20;
  localparam int WORDS          = 1 << (ADDR_BITS - 2);
  localparam int SECTOR_WORDS   = 65536 / 4;
  localparam int WATCHDOG_LIMIT = 800000;
  localparam int PHASE_ITEMS    = 130;

  // Density-dependent query entries: size code per density, then the first erase region
  localparam logic [7:0] DENSITY_CODE [4] = '{8'h18, 8'h19, 8'h1A, 8'h1B};
  localparam logic [7:0] REGION_TBL [4][4] = '{
    '{8'h7F, 8'h00, 8'h00, 8'h02},
    '{8'hFF, 8'h00, 8'h00, 8'h02},
    '{8'hFF, 8'h01, 8'h00, 8'h02},
    '{8'hFF, 8'h03, 8'h00, 8'h02}
  };
  localparam logic [3:0] HOT_SECTORS [3] = '{4'h0, 4'h5, 4'hF};
  localparam logic [1:0] PHASE_SIZES [4] = '{2'd3, 2'd1, 2'd2, 2'd0};

  typedef struct packed {
    logic [2:0]           kind;
    logic [ADDR_BITS-1:0] addr;
    logic [15:0]          data;
  } flash_access_t;

  typedef struct packed {
    logic [31:0]   rdata;
    flash_access_t acc;
  } read_check_t;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_we          = 1'b0;
  logic [1:0]           cfg_wdata       = 2'd0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic [2:0]           in_req_type     = 3'd0;
  logic [ADDR_BITS-1:0] in_byte_address = '0;
  logic [15:0]          in_write_data   = 16'd0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [31:0]          out_read_data;

  // Predicted device state: command mode, reported density and the array image
  cfc_pkg::mode_t dev_mode;
  logic [1:0] qry_size;
  bit [31:0] flash_img [WORDS];

  flash_access_t pending_accesses [$];
  read_check_t   expected_data [$];

  bit in_taken;
  bit out_taken;
  bit idle_on = 1'b1;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;
  int mismatch_cnt = 0;
  int queued_total = 0;
  int erase_budget = 12;

  cfi_flash_command_fsm_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_byte_address (in_byte_address),
    .in_write_data   (in_write_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data)
  );

  always #6 clk = ~clk;

  // Query table byte at a halfword address; zero outside the table
  function automatic logic [7:0] qry_byte(input logic [18:0] word);
    logic [18:0] idx;
    if (word < 19'd16 || word - 19'd16 >= 19'(cfc_pkg::CFI_LEN)) return 8'h00;
    idx = word - 19'd16;
    if (idx == 19'(cfc_pkg::CFI_SIZE_IDX)) return DENSITY_CODE[qry_size];
    if (idx >= 19'(cfc_pkg::CFI_REGION_IDX) && idx < 19'(cfc_pkg::CFI_REGION_IDX) + 19'd4)
      return REGION_TBL[qry_size][idx - 19'(cfc_pkg::CFI_REGION_IDX)];
    return cfc_pkg::CFI_BASE[idx[6:0]];
  endfunction

  // Advance the predicted device by one bus transaction and return its read data
  function automatic logic [31:0] flash_predict(input flash_access_t acc);
    logic [18:0] word;
    logic [17:0] widx;
    logic [17:0] base;
    logic [31:0] w;
    logic [31:0] r;
    logic        wr;
    logic        rd;
    logic        rd_narrow;
    logic        at_unlock1;
    logic        at_unlock2;
    word       = acc.addr[ADDR_BITS-1:1];
    widx       = acc.addr[ADDR_BITS-1:2];
    w          = flash_img[widx];
    wr         = (acc.kind == cfc_pkg::REQ_WR16);
    rd         = (acc.kind <= cfc_pkg::REQ_RD32);
    rd_narrow  = (acc.kind == cfc_pkg::REQ_RD16 || acc.kind == cfc_pkg::REQ_RD8);
    at_unlock1 = (word == 19'(cfc_pkg::WORD_UNLOCK1));
    at_unlock2 = (word == 19'(cfc_pkg::WORD_UNLOCK2));
    r          = 32'd0;
    case (dev_mode)
      cfc_pkg::M_READ: begin
        if (wr && word == 19'(cfc_pkg::WORD_CFI_QUERY) &&
            acc.data == cfc_pkg::CMD_CFI_QUERY) begin
          dev_mode = cfc_pkg::M_CFI;
        end else if (wr && at_unlock1 && acc.data == cfc_pkg::CMD_UNLOCK1) begin
          dev_mode = cfc_pkg::M_UNLOCK;
        end else if (rd) begin
          // Big-endian image: byte 0 is the top byte, halfword 0 the upper half
          if (acc.kind == cfc_pkg::REQ_RD8)
            r = {24'd0, 8'(w >> {~acc.addr[1:0], 3'b000})};
          else if (acc.kind == cfc_pkg::REQ_RD16)
            r = {16'd0, acc.addr[1] ? w[15:0] : w[31:16]};
          else r = w;
        end
      end
      cfc_pkg::M_CFI: begin
        if (wr && acc.data == cfc_pkg::CMD_RESET) dev_mode = cfc_pkg::M_READ;
        else if (rd_narrow) r = {24'd0, qry_byte(word)};
      end
      cfc_pkg::M_UNLOCK: begin
        if (wr && at_unlock2 && acc.data == cfc_pkg::CMD_UNLOCK2)
          dev_mode = cfc_pkg::M_COMMAND;
      end
      cfc_pkg::M_COMMAND: begin
        if (wr && at_unlock1) begin
          case (acc.data)
            cfc_pkg::CMD_ID:      dev_mode = cfc_pkg::M_ID;
            cfc_pkg::CMD_ERASE:   dev_mode = cfc_pkg::M_ERASE_SETUP;
            cfc_pkg::CMD_PROGRAM: dev_mode = cfc_pkg::M_PROGRAM;
            default:              ;
          endcase
        end
      end
      cfc_pkg::M_PROGRAM: begin
        if (wr) begin
          if (acc.addr[1]) flash_img[widx] = {w[31:16], acc.data};
          else flash_img[widx] = {acc.data, w[15:0]};
          dev_mode = cfc_pkg::M_READ;
        end
      end
      cfc_pkg::M_ERASE_SETUP: begin
        if (wr && at_unlock1 && acc.data == cfc_pkg::CMD_UNLOCK1)
          dev_mode = cfc_pkg::M_ERASE_UNLK;
      end
      cfc_pkg::M_ERASE_UNLK: begin
        if (wr && at_unlock2 && acc.data == cfc_pkg::CMD_UNLOCK2)
          dev_mode = cfc_pkg::M_ERASE_CMD;
      end
      cfc_pkg::M_ERASE_CMD: begin
        if (wr && at_unlock1 && acc.data == cfc_pkg::CMD_CHIP_ERS) begin
          // Chip erase leaves the array alone
          dev_mode = cfc_pkg::M_READ;
        end else if (wr && acc.data == cfc_pkg::CMD_SEC_ERASE) begin
          base = {acc.addr[ADDR_BITS-1:16], 14'd0};
          for (int k = 0; k < SECTOR_WORDS; k++) flash_img[base + 18'(k)] = '1;
          dev_mode = cfc_pkg::M_READ;
        end
      end
      cfc_pkg::M_ID: begin
        if (wr && acc.data == cfc_pkg::CMD_RESET) dev_mode = cfc_pkg::M_READ;
        else if (rd_narrow && word < 19'(cfc_pkg::ID_LEN))
          r = {24'd0, cfc_pkg::ID_TABLE[word[3:0]]};
      end
      default: dev_mode = cfc_pkg::M_READ;
    endcase
    return r;
  endfunction

  // Idle length for either side: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic [ADDR_BITS-1:0] cmd_addr(input logic [11:0] word);
    return ADDR_BITS'({word, 1'($urandom)});
  endfunction

  // Bias addresses toward a few sectors so reads see programmed and erased data
  function automatic logic [ADDR_BITS-1:0] pick_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return {HOT_SECTORS[$urandom_range(0, 2)], 10'h000, 6'($urandom)};
    if (r < 8) return ADDR_BITS'($urandom_range(0, 'hFFF));
    return ADDR_BITS'($urandom);
  endfunction

  task automatic queue_access(input logic [2:0] kind, input logic [ADDR_BITS-1:0] addr,
                              input logic [15:0] data);
    flash_access_t acc;
    acc = '{kind: kind, addr: addr, data: data};
    pending_accesses.push_back(acc);
    queued_total++;
  endtask

  task automatic queue_unlock();
    queue_access(cfc_pkg::REQ_WR16, cmd_addr(cfc_pkg::WORD_UNLOCK1), cfc_pkg::CMD_UNLOCK1);
    queue_access(cfc_pkg::REQ_WR16, cmd_addr(cfc_pkg::WORD_UNLOCK2), cfc_pkg::CMD_UNLOCK2);
  endtask

  // Write the density register; the caller guarantees the bus is quiet
  task automatic set_size(input logic [1:0] code);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Hold until every queued transaction went in and every result came back
  task automatic drain();
    while (pending_accesses.size() != 0 || in_valid || expected_data.size() != 0)
      @(posedge clk);
  endtask

  // Mostly complete command sequences with random content, plus noise and broken ones
  task automatic gen_phase(input int n);
    int target;
    int sel;
    logic [ADDR_BITS-1:0] a;
    logic [15:0] d;
    target = queued_total + n;
    while (queued_total < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        // Program one halfword, then read around it
        a = pick_addr();
        d = $urandom;
        if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        queue_unlock();
        queue_access(cfc_pkg::REQ_WR16, cmd_addr(cfc_pkg::WORD_UNLOCK1), cfc_pkg::CMD_PROGRAM);
        queue_access(cfc_pkg::REQ_WR16, a, d);
        repeat ($urandom_range(1, 3))
          queue_access(3'($urandom_range(0, 2)), {a[ADDR_BITS-1:2], 2'($urandom)}, $urandom);
      end else if (sel < 45) begin
        repeat ($urandom_range(1, 4))
          queue_access(3'($urandom_range(0, 2)), pick_addr(), $urandom);
      end else if (sel < 60) begin
        // Query mode: reads across the table and just outside it, then leave
        queue_access(cfc_pkg::REQ_WR16, cmd_addr(cfc_pkg::WORD_CFI_QUERY),
                     cfc_pkg::CMD_CFI_QUERY);
        repeat ($urandom_range(2, 5)) begin
          if ($urandom_range(0, 6) == 0) a = pick_addr();
          else a = ADDR_BITS'({7'($urandom_range('h0C, 'h55)), 1'($urandom)});
          queue_access(3'($urandom_range(0, 2)), a, $urandom);
        end
        queue_access(cfc_pkg::REQ_WR16, pick_addr(), cfc_pkg::CMD_RESET);
      end else if (sel < 72) begin
        queue_unlock();
        queue_access(cfc_pkg::REQ_WR16, cmd_addr(cfc_pkg::WORD_UNLOCK1), cfc_pkg::CMD_ID);
        repeat ($urandom_range(2, 4))
          queue_access(3'($urandom_range(0, 2)),
                       ADDR_BITS'({5'($urandom_range(0, 'h12)), 1'($urandom)}), $urandom);
        queue_access(cfc_pkg::REQ_WR16, pick_addr(), cfc_pkg::CMD_RESET);
      end else if (sel < 78 && erase_budget > 0) begin
        // Sector erase is slow, so keep the count low; chip erase is cheap
        queue_unlock();
        queue_access(cfc_pkg::REQ_WR16, cmd_addr(cfc_pkg::WORD_UNLOCK1), cfc_pkg::CMD_ERASE);
        queue_unlock();
        if ($urandom_range(0, 3) == 0) begin
          a = cmd_addr(cfc_pkg::WORD_UNLOCK1);
          queue_access(cfc_pkg::REQ_WR16, a, cfc_pkg::CMD_CHIP_ERS);
        end else begin
          a = pick_addr();
          queue_access(cfc_pkg::REQ_WR16, a, cfc_pkg::CMD_SEC_ERASE);
          erase_budget--;
        end
        queue_access(cfc_pkg::REQ_RD32, pick_addr(), $urandom);
      end else begin
        // Noise and broken sequences; leave sector erase out of the command mix
        if ($urandom_range(0, 1)) queue_unlock();
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 3))
            0:       a = cmd_addr(cfc_pkg::WORD_UNLOCK1);
            1:       a = cmd_addr(cfc_pkg::WORD_UNLOCK2);
            2:       a = cmd_addr(cfc_pkg::WORD_CFI_QUERY);
            default: a = pick_addr();
          endcase
          case ($urandom_range(0, 8))
            0:       d = cfc_pkg::CMD_UNLOCK1;
            1:       d = cfc_pkg::CMD_UNLOCK2;
            2:       d = cfc_pkg::CMD_ID;
            3:       d = cfc_pkg::CMD_ERASE;
            4:       d = cfc_pkg::CMD_PROGRAM;
            5:       d = cfc_pkg::CMD_CFI_QUERY;
            6:       d = cfc_pkg::CMD_RESET;
            7:       d = cfc_pkg::CMD_CHIP_ERS;
            default: d = $urandom;
          endcase
          queue_access(3'($urandom_range(0, 4)), a, d);
        end
      end
    end
  endtask

  // Driver: present the next pending transaction at the falling edge and hold it while stalled
  always @(negedge clk) begin : drive_in
    flash_access_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_accesses.size() != 0) begin
        nxt             = pending_accesses.pop_front();
        in_req_type     <= nxt.kind;
        in_byte_address <= nxt.addr;
        in_write_data   <= nxt.data;
        in_valid        <= 1'b1;
        in_gap          = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (out_gap != 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      out_gap = pick_gap();
    end
  end

  // Monitor: predict on every accepted transaction, check every accepted result
  always @(posedge clk) begin : monitor
    flash_access_t acc_now;
    read_check_t   item;
    in_taken  = rst_n && in_valid && !in_stall;
    out_taken = rst_n && out_valid && !out_stall;
    if (rst_n && cfg_we) qry_size = cfg_wdata;
    // Take the input first, so a same-edge result still finds its expectation
    if (in_taken) begin
      acc_now = '{kind: in_req_type, addr: in_byte_address, data: in_write_data};
      item.rdata = flash_predict(acc_now);
      item.acc   = acc_now;
      expected_data.push_back(item);
    end
    if (out_taken) begin
      if (expected_data.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result: read_data %08h", out_read_data);
      end else begin
        item = expected_data.pop_front();
        if (out_read_data !== item.rdata) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: kind %0d addr %05h data %04h: read_data expected %08h got %08h",
                     item.acc.kind, item.acc.addr, item.acc.data, item.rdata, out_read_data);
        end
      end
    end
    // Watchdog: long silences are legal during the clearing sweep and sector erases
    if (in_taken || out_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    foreach (flash_img[i]) flash_img[i] = '1;
    dev_mode = cfc_pkg::M_READ;
    qry_size = 2'd3;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Smallest density first; writes are taken during the clearing sweep
    set_size(2'd0);

    // Directed: every access kind, address extremes, each command but chip erase and the odd reads
    queue_access(cfc_pkg::REQ_RD32, 20'h00000, 16'h0000);
    queue_unlock();
    queue_access(cfc_pkg::REQ_WR16, cmd_addr(cfc_pkg::WORD_UNLOCK1), cfc_pkg::CMD_PROGRAM);
    queue_access(cfc_pkg::REQ_WR16, 20'h00000, 16'h1234);
    queue_access(cfc_pkg::REQ_RD8, 20'h00001, 16'hFFFF);
    queue_access(cfc_pkg::REQ_RD16, 20'hFFFFE, 16'h0000);
    queue_access(cfc_pkg::REQ_WR8, cmd_addr(cfc_pkg::WORD_UNLOCK1), cfc_pkg::CMD_UNLOCK1);
    queue_access(cfc_pkg::REQ_WR16, cmd_addr(cfc_pkg::WORD_CFI_QUERY), cfc_pkg::CMD_CFI_QUERY);
    queue_access(cfc_pkg::REQ_RD16, 20'h00020, 16'h0000);
    queue_access(cfc_pkg::REQ_RD8, 20'h0004E, 16'h0000);
    queue_access(cfc_pkg::REQ_RD32, 20'h0005A, 16'h0000);
    queue_access(cfc_pkg::REQ_RD16, 20'h000A2, 16'h0000);
    queue_access(cfc_pkg::REQ_WR16, 20'h00000, cfc_pkg::CMD_RESET);
    queue_unlock();
    queue_access(cfc_pkg::REQ_WR16, cmd_addr(cfc_pkg::WORD_UNLOCK1), cfc_pkg::CMD_ID);
    queue_access(cfc_pkg::REQ_RD8, 20'h00002, 16'h0000);
    queue_access(cfc_pkg::REQ_RD16, 20'h00020, 16'h0000);
    queue_access(cfc_pkg::REQ_WR16, 20'hFFFFF, cfc_pkg::CMD_RESET);
    queue_unlock();
    queue_access(cfc_pkg::REQ_WR16, cmd_addr(cfc_pkg::WORD_UNLOCK1), cfc_pkg::CMD_ERASE);
    queue_unlock();
    queue_access(cfc_pkg::REQ_WR16, 20'h0FFFF, cfc_pkg::CMD_SEC_ERASE);
    queue_access(cfc_pkg::REQ_RD32, 20'h00000, 16'h0000);

    // Random phases, each at its own density; one phase runs with no idling at all
    for (int p = 0; p < 4; p++) begin
      drain();
      set_size(PHASE_SIZES[p]);
      idle_on = (p != 1);
      gen_phase(PHASE_ITEMS);
    end
    drain();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
